@@ sv/sds_pkg.sv @@
// Shared types, constants and helpers for the short-name directory search unit.
// No dependencies; used by every module of the block.
package sds_pkg;

	localparam int INDEX_BITS = 12;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int POS_W = 4;
	localparam int CHR_W = 8;
	localparam int BASE_W = 64;
	localparam int EXT_W = 24;
	localparam int BASE_CHARS = BASE_W / CHR_W;
	localparam int EXT_CHARS = EXT_W / CHR_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [BASE_W-1:0] SPACES_BASE = {BASE_CHARS{8'h20}};
	localparam logic [EXT_W-1:0] SPACES_EXT = {EXT_CHARS{8'h20}};
	localparam logic [CHR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHR_W-1:0] CH_DOT = 8'h2E;
	localparam logic [CHR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHR_W-1:0] CH_LOW_Z = 8'h7A;
	localparam logic [CHR_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [CHR_W-1:0] ATTR_SKIP = 8'h18;
	localparam logic [POS_W-1:0] BASE_LEN = POS_W'(BASE_CHARS);
	localparam logic [POS_W-1:0] NAME_LEN = POS_W'(BASE_CHARS + EXT_CHARS);
	localparam logic [CNT_W-1:0] MAX_RESET = 13'd224;

	typedef enum logic [1:0] {
		PH_NAME    = 2'd0,
		PH_SEARCH  = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_CHAR  = 1'b0,
		REQ_ENTRY = 1'b1
	} req_t;

	typedef struct packed {
		req_t              kind;
		logic [CHR_W-1:0]  chr;
		logic              is_nul;
		logic              is_dot;
		logic              first_nul;
		logic              skip;
		logic [BASE_W-1:0] base;
		logic [EXT_W-1:0]  ext;
	} item_t;

	function automatic logic [IDX_W-1:0] index_of(input logic [CNT_W-1:0] cnt);
		logic [31:0] w;
		w = 32'(cnt) & ((32'd1 << INDEX_BITS) - 32'd1);
		return w[IDX_W-1:0];
	endfunction

endpackage

@@ sv/short_name_directory_search_unit.sv @@
// Top level of the short-name directory search unit.
// Depends on sds_pkg, sds_front, sds_queue and sds_back.
//
// Query name characters (req_type 0) build an 11-character space-padded 8.3 name; a zero
// character ends it and starts the search, after which directory entries (req_type 1) are
// matched one per beat. The unit takes one beat per cycle: the front end classifies each beat
// into a four-entry queue, and the back end retires one queued beat per cycle while no result
// is held on the output. A result is registered onto out_valid as the back end retires the
// beat causing it. Intake stalls only when the queue is full, which happens only while a
// result is held on the output by out_ready low.
// max_entries may be written at any time the unit is idle; cfg_ready is always high.
module short_name_directory_search_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [sds_pkg::CHR_W-1:0]     name_char,
	input  logic [sds_pkg::BASE_W-1:0]    entry_base,
	input  logic [sds_pkg::EXT_W-1:0]     entry_ext,
	input  logic [sds_pkg::CHR_W-1:0]     entry_attr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    result_status,
	output logic [sds_pkg::IDX_W-1:0]     entry_index,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sds_pkg::CNT_W-1:0]     max_entries
);

	sds_pkg::item_t push_item;
	sds_pkg::item_t q_head;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;

	assign cfg_ready = 1'b1;

	sds_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.name_char  (name_char),
		.entry_base (entry_base),
		.entry_ext  (entry_ext),
		.entry_attr (entry_attr),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	sds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	sds_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.pop           (pop),
		.cfg_valid     (cfg_valid),
		.cfg_data      (max_entries),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_status (result_status),
		.entry_index   (entry_index)
	);

endmodule

@@ sv/sds_front.sv @@
// Front end: accepts input beats and classifies them into queue items.
// Depends on sds_pkg.
module sds_front (
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [sds_pkg::CHR_W-1:0]       name_char,
	input  logic [sds_pkg::BASE_W-1:0]      entry_base,
	input  logic [sds_pkg::EXT_W-1:0]       entry_ext,
	input  logic [sds_pkg::CHR_W-1:0]       entry_attr,
	input  logic                            q_full,
	output logic                            push,
	output sds_pkg::item_t                  push_item
);

	logic is_lower;

	assign in_ready = !q_full;
	assign push = in_valid && !q_full;
	assign is_lower = (name_char >= sds_pkg::CH_LOW_A) && (name_char <= sds_pkg::CH_LOW_Z);

	always_comb begin
		push_item.kind = sds_pkg::req_t'(req_type);
		push_item.chr = is_lower ? name_char - sds_pkg::CASE_OFFSET : name_char;
		push_item.is_nul = (name_char == sds_pkg::CH_NUL);
		push_item.is_dot = (name_char == sds_pkg::CH_DOT);
		push_item.first_nul = (entry_base[sds_pkg::BASE_W-1 -: sds_pkg::CHR_W] == sds_pkg::CH_NUL);
		push_item.skip = |(entry_attr & sds_pkg::ATTR_SKIP);
		push_item.base = entry_base;
		push_item.ext = entry_ext;
	end

endmodule

@@ sv/sds_queue.sv @@
// Short FIFO of classified items between front and back end.
// Depends on sds_pkg.
module sds_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sds_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output sds_pkg::item_t head
);

	sds_pkg::item_t slot_q [sds_pkg::QDEPTH];
	logic [sds_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sds_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sds_pkg::QPTR_W:0]   count_q;

	assign full = (count_q == (sds_pkg::QPTR_W+1)'(sds_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/sds_back.sv @@
// Back end: query name assembly, directory entry matching and result register.
// Depends on sds_pkg.
module sds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  sds_pkg::item_t                q_head,
	output logic                          pop,
	input  logic                          cfg_valid,
	input  logic [sds_pkg::CNT_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    result_status,
	output logic [sds_pkg::IDX_W-1:0]     entry_index
);

	sds_pkg::phase_t              phase_q, phase_d;
	logic [sds_pkg::BASE_W-1:0]   query_base_q, query_base_d;
	logic [sds_pkg::EXT_W-1:0]    query_ext_q, query_ext_d;
	logic [sds_pkg::POS_W-1:0]    pos_q, pos_d;
	logic [sds_pkg::CNT_W-1:0]    seen_q, seen_d, seen_inc;
	logic [sds_pkg::CNT_W-1:0]    max_entries_q;
	logic                         out_valid_q;
	sds_pkg::status_t             status_q, status_d;
	logic [sds_pkg::IDX_W-1:0]    index_q, index_d;
	logic                         emit;
	logic                         too_long;

	assign pop = q_not_empty && (!out_valid_q || out_ready);
	assign seen_inc = seen_q + 1'b1;
	assign out_valid = out_valid_q;
	assign result_status = status_q;
	assign entry_index = index_q;

	always_comb begin
		phase_d = phase_q;
		query_base_d = query_base_q;
		query_ext_d = query_ext_q;
		pos_d = pos_q;
		seen_d = seen_q;
		emit = 1'b0;
		too_long = 1'b0;
		status_d = sds_pkg::ST_NOT_FOUND;
		index_d = '0;
		if (pop) begin
			case (phase_q)
				sds_pkg::PH_SEARCH: begin
					if (q_head.kind == sds_pkg::REQ_ENTRY) begin
						if (seen_q >= max_entries_q || q_head.first_nul) begin
							emit = 1'b1;
						end else if (!q_head.skip && q_head.base == query_base_q &&
								q_head.ext == query_ext_q) begin
							emit = 1'b1;
							status_d = sds_pkg::ST_FOUND;
							index_d = sds_pkg::index_of(seen_q);
						end else begin
							seen_d = seen_inc;
							emit = (seen_inc >= max_entries_q);
						end
					end
				end
				sds_pkg::PH_DISCARD: begin
					if (q_head.kind == sds_pkg::REQ_CHAR && q_head.is_nul) begin
						query_base_d = sds_pkg::SPACES_BASE;
						query_ext_d = sds_pkg::SPACES_EXT;
						pos_d = '0;
						seen_d = '0;
						phase_d = sds_pkg::PH_NAME;
					end
				end
				default: begin
					if (q_head.kind == sds_pkg::REQ_CHAR) begin
						if (q_head.is_nul) begin
							phase_d = sds_pkg::PH_SEARCH;
							seen_d = '0;
							emit = (max_entries_q == '0);
						end else if (pos_q >= sds_pkg::NAME_LEN) begin
							emit = 1'b1;
							too_long = 1'b1;
							status_d = sds_pkg::ST_TOO_LONG;
						end else if (q_head.is_dot && pos_q <= sds_pkg::BASE_LEN) begin
							pos_d = sds_pkg::BASE_LEN;
						end else begin
							for (int i = 0; i < sds_pkg::BASE_CHARS; i++) begin
								if (pos_q == sds_pkg::POS_W'(i)) begin
									query_base_d[(sds_pkg::BASE_CHARS-1-i)*sds_pkg::CHR_W +:
										sds_pkg::CHR_W] = q_head.chr;
								end
							end
							for (int j = 0; j < sds_pkg::EXT_CHARS; j++) begin
								if (pos_q == sds_pkg::POS_W'(sds_pkg::BASE_CHARS + j)) begin
									query_ext_d[(sds_pkg::EXT_CHARS-1-j)*sds_pkg::CHR_W +:
										sds_pkg::CHR_W] = q_head.chr;
								end
							end
							pos_d = pos_q + 1'b1;
						end
					end
				end
			endcase
			if (emit) begin
				query_base_d = sds_pkg::SPACES_BASE;
				query_ext_d = sds_pkg::SPACES_EXT;
				pos_d = '0;
				seen_d = '0;
				phase_d = too_long ? sds_pkg::PH_DISCARD : sds_pkg::PH_NAME;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sds_pkg::PH_NAME;
			query_base_q <= sds_pkg::SPACES_BASE;
			query_ext_q <= sds_pkg::SPACES_EXT;
			pos_q <= '0;
			seen_q <= '0;
			max_entries_q <= sds_pkg::MAX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			query_base_q <= query_base_d;
			query_ext_q <= query_ext_d;
			pos_q <= pos_d;
			seen_q <= seen_d;
			if (cfg_valid) begin
				max_entries_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_d;
			index_q <= index_d;
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (query_base_q == sds_pkg::SPACES_BASE && query_ext_q == sds_pkg::SPACES_EXT
			&& pos_q == '0 && seen_q == '0))
		else $error("query not cleared after result");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= sds_pkg::NAME_LEN)
		else $error("name position out of range");

	a_discard_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sds_pkg::PH_DISCARD |-> pos_q == '0)
		else $error("position not cleared while discarding");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != sds_pkg::ST_FOUND |-> index_q == '0)
		else $error("nonzero index on a result other than found");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(index_q))
		else $error("pending result dropped or overwritten");

endmodule
